FILE: rtl/utfss_pkg.sv
// utfss_pkg: types, constants and byte classifiers of the utf-8 sentence splitter
// no dependencies; used by utfss_step, utf8_sentence_splitter and utfss_checker

package utfss_pkg;

    localparam int POSITION_WIDTH_DEFAULT = 32;
    localparam int TEXT_POSITION_WIDTH    = 32;
    localparam int CHAR_CODE_WIDTH        = 24;
    localparam int MARK_COUNT             = 16;

    localparam logic [7:0] DOLLAR_BYTE = 8'h24;

    typedef enum logic [1:0] {
        KIND_CHAR    = 2'd0,
        KIND_END     = 2'd1,
        KIND_DISCARD = 2'd2
    } kind_t;

    typedef struct packed {
        logic        formula_mode;
        logic [1:0]  byte_index;
        logic [15:0] partial_bytes;
        logic        sentence_open;
    } ctrl_t;

    typedef struct packed {
        logic                       advance;
        logic                       emit;
        kind_t                      kind;
        logic [CHAR_CODE_WIDTH-1:0] char_code;
    } step_t;

    // full-width punctuation, first utf-8 byte most significant
    localparam logic [CHAR_CODE_WIDTH-1:0] MARK_CODES [MARK_COUNT] = '{
        24'hE38081, 24'hEFBC8C, 24'hEFBC9F, 24'hEFBC88,
        24'hEFBC89, 24'hE38082, 24'hEFBC9B, 24'hEFBC9A,
        24'hE2809C, 24'hE2809D, 24'hE291A0, 24'hE291A1,
        24'hE291A2, 24'hE291A5, 24'hE28693, 24'hE2978F
    };

    function automatic logic is_alnum(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) ||
               (b >= 8'h30 && b <= 8'h39);
    endfunction

    function automatic logic is_break(input logic [7:0] b);
        logic hit;
        unique case (b)
            8'h2C, 8'h3A, 8'h3B, 8'h3D, 8'h2D, 8'h26, 8'h5E, 8'h3F,
            8'h2E, 8'h23, 8'h2B, 8'h25, 8'h7E, 8'h5F, 8'h20, 8'h2F,
            8'h5B, 8'h5D, 8'h3C, 8'h3E, 8'h28, 8'h29, 8'h7B, 8'h7D,
            8'h22, 8'h5C, 8'h27, 8'h0D, 8'h0A, 8'h09: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic logic is_mark(input logic [CHAR_CODE_WIDTH-1:0] code);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k < MARK_COUNT; k++) begin
            hit = hit | (MARK_CODES[k] == code);
        end
        return hit;
    endfunction

endpackage

FILE: rtl/utfss_step.sv
// utfss_step: next control state and result of one text byte, combinational
// depends on utfss_pkg

module utfss_step (
    input  logic [7:0]      text_byte,
    input  utfss_pkg::ctrl_t ctrl_cur,
    output utfss_pkg::ctrl_t ctrl_nxt,
    output utfss_pkg::step_t step
);

    logic [utfss_pkg::CHAR_CODE_WIDTH-1:0] code;

    assign code = {ctrl_cur.partial_bytes, text_byte};

    always_comb begin
        ctrl_nxt       = ctrl_cur;
        step.advance   = 1'b0;
        step.emit      = 1'b0;
        step.kind      = utfss_pkg::KIND_CHAR;
        step.char_code = '0;
        priority if (text_byte == utfss_pkg::DOLLAR_BYTE) begin
            step.advance          = 1'b1;
            ctrl_nxt.formula_mode = ~ctrl_cur.formula_mode;
        end else if (ctrl_cur.formula_mode || utfss_pkg::is_alnum(text_byte)) begin
            step.advance = 1'b1;
        end else if (utfss_pkg::is_break(text_byte)) begin
            step.advance = 1'b1;
            if (ctrl_cur.sentence_open) begin
                ctrl_nxt.sentence_open = 1'b0;
                step.emit = 1'b1;
                step.kind = (ctrl_cur.byte_index == 2'd0) ? utfss_pkg::KIND_END
                                                          : utfss_pkg::KIND_DISCARD;
            end
        end else if (ctrl_cur.byte_index < 2'd2) begin
            // collect the first two bytes of a character
            if (ctrl_cur.byte_index == 2'd0) begin
                ctrl_nxt.partial_bytes[15:8] = text_byte;
            end else begin
                ctrl_nxt.partial_bytes[7:0] = text_byte;
            end
            ctrl_nxt.byte_index = ctrl_cur.byte_index + 2'd1;
        end else begin
            ctrl_nxt.byte_index = 2'd0;
            step.advance        = 1'b1;
            if (utfss_pkg::is_mark(code)) begin
                if (ctrl_cur.sentence_open) begin
                    ctrl_nxt.sentence_open = 1'b0;
                    step.emit = 1'b1;
                    step.kind = utfss_pkg::KIND_END;
                end
            end else begin
                ctrl_nxt.sentence_open = 1'b1;
                step.emit      = 1'b1;
                step.kind      = utfss_pkg::KIND_CHAR;
                step.char_code = code;
            end
        end
    end

endmodule

FILE: rtl/utf8_sentence_splitter.sv
// utf8_sentence_splitter: top level, byte stream in, sentence items out
// depends on utfss_pkg and utfss_step
//
// usage:
//   s_ channel: one text byte per item in s_tdata[7:0]
//   m_ channel: zero or one result item per input byte; m_tuser carries the
//   kind (character, sentence end, open sentence discarded), m_tdata the
//   24-bit character code and the 32-bit position after that byte
//   output: a result is on m_ in the cycle after its byte is accepted
//   throughput: one byte per cycle while m_ does not stall, set by the single output register;
//   classification, the mark compare and the position add sit between the
//   input port and that register
//   stall: while a result waits with m_tready low, s_tready is low; a result
//   taken in the same cycle frees the register for the next byte at once
//   reset: aresetn low clears the formula flag, the character assembly, the
//   sentence flag, the position counter and the output valid
//   the position counter is POSITION_WIDTH bits and wraps; m_tdata shows its
//   low 32 bits, zero-extended when narrower

module utf8_sentence_splitter #(
    parameter int POSITION_WIDTH = utfss_pkg::POSITION_WIDTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // text_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // char_code[23:0], text_position[55:24]
    output logic [1:0]  m_tuser    // kind
);

    utfss_pkg::ctrl_t ctrl_reg, ctrl_next;
    utfss_pkg::step_t step;

    logic [POSITION_WIDTH-1:0] pos_reg, pos_next;
    logic [63:0]               pos_wide;
    logic                      m_valid_reg;
    logic [1:0]                kind_reg;
    logic [23:0]               code_reg;
    logic [31:0]               tpos_reg;
    logic                      accept;

    utfss_step u_step (
        .text_byte (s_tdata),
        .ctrl_cur  (ctrl_reg),
        .ctrl_nxt  (ctrl_next),
        .step      (step)
    );

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign pos_next = step.advance ? pos_reg + POSITION_WIDTH'(1) : pos_reg;
    assign pos_wide = 64'(pos_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg    <= '0;
            pos_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                ctrl_reg    <= ctrl_next;
                pos_reg     <= pos_next;
                m_valid_reg <= step.emit;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && step.emit) begin
            kind_reg <= step.kind;
            code_reg <= step.char_code;
            tpos_reg <= pos_wide[31:0];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {tpos_reg, code_reg};
    assign m_tuser  = kind_reg;

endmodule

FILE: rtl/utfss_checker.sv
// utfss_checker: port-level assertions of the sentence splitter, bound to the top
// depends on utfss_pkg and utf8_sentence_splitter

module utfss_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // no byte taken while a result is stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("byte accepted over a stalled result");

    // empty output register never blocks input
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");

    // markers carry a zero code and a legal kind
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != utfss_pkg::KIND_CHAR |->
            (m_tuser == utfss_pkg::KIND_END || m_tuser == utfss_pkg::KIND_DISCARD) &&
            m_tdata[23:0] == 24'd0)
        else $error("bad marker item");

    // accepted byte is known
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |-> !$isunknown(s_tdata))
        else $error("unknown byte accepted");

endmodule

bind utf8_sentence_splitter utfss_checker u_utfss_checker (.*);
